// ----- design/gap_buffer_text_edit_engine_unit_defines.svh -----
// assertion macros for the gap buffer edit engine
// used by the top level only, expects clk and arst_n in scope
`ifndef GAP_BUFFER_TEXT_EDIT_ENGINE_UNIT_DEFINES_SVH
`define GAP_BUFFER_TEXT_EDIT_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication
`define GBT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gap buffer engine check failed");

// next-cycle implication
`define GBT_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gap buffer engine check failed");

`endif

// ----- design/gbt_pkg.sv -----
// types and constants of the gap buffer edit engine
// no dependencies
package gbt_pkg;

	localparam logic [7:0] KEY_CUT      = 8'h0B;
	localparam logic [7:0] KEY_COPY     = 8'h03;
	localparam logic [7:0] KEY_PASTE    = 8'h15;
	localparam logic [7:0] KEY_CTRL_A   = 8'h01;
	localparam logic [7:0] KEY_CTRL_E   = 8'h05;
	localparam logic [7:0] KEY_CR       = 8'h0D;
	localparam logic [7:0] KEY_LEFT     = 8'h9D;
	localparam logic [7:0] KEY_RIGHT    = 8'h1D;
	localparam logic [7:0] KEY_UP       = 8'h91;
	localparam logic [7:0] KEY_DOWN     = 8'h11;
	localparam logic [7:0] KEY_HOME     = 8'h13;
	localparam logic [7:0] KEY_DEL      = 8'h14;
	localparam logic [7:0] KEY_PRINT_LO = 8'h20;
	localparam logic [7:0] KEY_PRINT_HI = 8'h7E;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_CLIP_FULL  = 3'd1;
	localparam logic [2:0] ST_NO_LINE    = 3'd2;
	localparam logic [2:0] ST_CLIP_EMPTY = 3'd3;
	localparam logic [2:0] ST_BUF_FULL   = 3'd4;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  key_code;
		logic [14:0] read_offset;
	} in_item_t;

	typedef struct packed {
		logic [15:0] cursor_pos;
		logic [15:0] doc_length;
		logic [15:0] cursor_column;
		logic [15:0] window_top;
		logic [11:0] clip_length;
		logic        dirty;
		logic [2:0]  status;
		logic [7:0]  read_char;
	} out_item_t;

	typedef enum logic [5:0] {
		OP_NOP, OP_LATCH, OP_RD_OFF, OP_RD_SAVE, OP_P_GS, OP_P_DEC, OP_P_INC,
		OP_RD_PM1, OP_RD_P, OP_PUT, OP_DEL, OP_T_GSM1, OP_T_GSP1, OP_T_P,
		OP_MV_CLAMP, OP_MVL_RD, OP_MVL_WR, OP_MVR_RD, OP_MVR_WR, OP_UD_SAVE,
		OP_P_AM1, OP_A_P, OP_UD_TGT, OP_CC_LE, OP_CNT_CLR, OP_CP_RD, OP_CP_WR,
		OP_CP_DONE, OP_CUT_FIX, OP_PS_RD, OP_PS_WR, OP_PS_DONE, OP_SET_ST,
		OP_TOP_A, OP_P_TOP, OP_P_TOP2, OP_FC_RD, OP_FC_CNT, OP_TOP_P1, OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [2:0] st;
	} dp_cmd_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] key;
		logic       p_zero;
		logic       p_ge_dl;
		logic       q_cr;
		logic       off_lt_dl;
		logic       gs_zero;
		logic       gs_lt_dl;
		logic       t_lt_gs;
		logic       t_gt_gs;
		logic       b_zero;
		logic       clip_ovf;
		logic       clip_zero;
		logic       paste_nofit;
		logic       cnt_eq_b;
		logic       cnt_eq_clip;
		logic       a_lt_top;
		logic       p_lt_a;
		logic       rows_ge_win;
		logic       out_free;
		logic       gap_ok;
	} dp_flags_t;

	typedef enum logic [5:0] {
		S_IDLE, S_DISPATCH, S_RD_WAIT, S_COL, S_COL2, S_HOME2,
		S_UD1, S_UD_DN, S_UD_DN2, S_UD_UP, S_UD3, S_UD4,
		S_CC1, S_CC2, S_CC3, S_CP_RD, S_CP_WR, S_CP_END, S_CUT2,
		S_PS_RD, S_PS_WR, S_LB, S_LB_CHK, S_LS, S_LS_CHK,
		S_MV, S_MV_LOOP, S_MVL_WR, S_MVR_WR,
		S_FOLLOW, S_FL1, S_FL2, S_FL_CNT, S_FL_CHK, S_FL_TRIM, S_FL_TRIM2, S_DONE
	} gbt_state_t;

endpackage

// ----- design/gbt_chan_if.sv -----
// valid/ready channel carrying one transaction payload
// payload type comes from gbt_pkg
interface gbt_chan_if #(parameter type payload_t = gbt_pkg::in_item_t);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- design/gbt_ctrl.sv -----
// sequencer of the gap buffer edit engine
// uses gbt_pkg command and flag types
module gbt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  gbt_pkg::dp_flags_t  flags,
	output gbt_pkg::dp_cmd_t    ctl
);

	gbt_pkg::gbt_state_t state_q, state_d, ret_q, ret_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbt_pkg::S_IDLE;
			ret_q   <= gbt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		in_ready = 1'b0;
		ctl.op   = gbt_pkg::OP_NOP;
		ctl.st   = gbt_pkg::ST_OK;
		case (state_q)
			gbt_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.op  = gbt_pkg::OP_LATCH;
					state_d = gbt_pkg::S_DISPATCH;
				end
			end
			gbt_pkg::S_DISPATCH: begin
				if (flags.req_type) begin
					if (flags.off_lt_dl) begin
						ctl.op  = gbt_pkg::OP_RD_OFF;
						state_d = gbt_pkg::S_RD_WAIT;
					end else begin
						state_d = gbt_pkg::S_COL;
					end
				end else begin
					state_d = gbt_pkg::S_FOLLOW;
					ret_d   = gbt_pkg::S_FOLLOW;
					case (flags.key) inside
						gbt_pkg::KEY_CR, [gbt_pkg::KEY_PRINT_LO:gbt_pkg::KEY_PRINT_HI]:
							ctl.op = gbt_pkg::OP_PUT;
						gbt_pkg::KEY_DEL:
							ctl.op = gbt_pkg::OP_DEL;
						gbt_pkg::KEY_LEFT: begin
							if (!flags.gs_zero) begin
								ctl.op  = gbt_pkg::OP_T_GSM1;
								state_d = gbt_pkg::S_MV;
							end
						end
						gbt_pkg::KEY_RIGHT: begin
							if (flags.gs_lt_dl) begin
								ctl.op  = gbt_pkg::OP_T_GSP1;
								state_d = gbt_pkg::S_MV;
							end
						end
						gbt_pkg::KEY_HOME, gbt_pkg::KEY_CTRL_A: begin
							ctl.op  = gbt_pkg::OP_P_GS;
							ret_d   = gbt_pkg::S_HOME2;
							state_d = gbt_pkg::S_LB;
						end
						gbt_pkg::KEY_CTRL_E: begin
							ctl.op  = gbt_pkg::OP_P_GS;
							ret_d   = gbt_pkg::S_HOME2;
							state_d = gbt_pkg::S_LS;
						end
						gbt_pkg::KEY_UP, gbt_pkg::KEY_DOWN: begin
							ctl.op  = gbt_pkg::OP_P_GS;
							ret_d   = gbt_pkg::S_UD1;
							state_d = gbt_pkg::S_LB;
						end
						gbt_pkg::KEY_CUT, gbt_pkg::KEY_COPY: begin
							ctl.op  = gbt_pkg::OP_P_GS;
							ret_d   = gbt_pkg::S_CC1;
							state_d = gbt_pkg::S_LB;
						end
						gbt_pkg::KEY_PASTE: begin
							if (flags.clip_zero) begin
								ctl.op = gbt_pkg::OP_SET_ST;
								ctl.st = gbt_pkg::ST_CLIP_EMPTY;
							end else if (flags.paste_nofit) begin
								ctl.op = gbt_pkg::OP_SET_ST;
								ctl.st = gbt_pkg::ST_BUF_FULL;
							end else begin
								ctl.op  = gbt_pkg::OP_CNT_CLR;
								state_d = gbt_pkg::S_PS_RD;
							end
						end
						default: ctl.op = gbt_pkg::OP_NOP;
					endcase
				end
			end
			gbt_pkg::S_RD_WAIT: begin
				ctl.op  = gbt_pkg::OP_RD_SAVE;
				state_d = gbt_pkg::S_COL;
			end
			gbt_pkg::S_COL: begin
				ctl.op  = gbt_pkg::OP_P_GS;
				ret_d   = gbt_pkg::S_COL2;
				state_d = gbt_pkg::S_LB;
			end
			gbt_pkg::S_COL2: begin
				ctl.op  = gbt_pkg::OP_A_P;
				state_d = gbt_pkg::S_DONE;
			end
			gbt_pkg::S_HOME2: begin
				ctl.op  = gbt_pkg::OP_T_P;
				ret_d   = gbt_pkg::S_FOLLOW;
				state_d = gbt_pkg::S_MV;
			end
			gbt_pkg::S_UD1: begin
				ctl.op = gbt_pkg::OP_UD_SAVE;
				if (flags.key == gbt_pkg::KEY_DOWN) begin
					state_d = gbt_pkg::S_UD_DN;
				end else if (flags.p_zero) begin
					state_d = gbt_pkg::S_FOLLOW;
				end else begin
					state_d = gbt_pkg::S_UD_UP;
				end
			end
			gbt_pkg::S_UD_DN: begin
				ctl.op  = gbt_pkg::OP_P_GS;
				ret_d   = gbt_pkg::S_UD_DN2;
				state_d = gbt_pkg::S_LS;
			end
			gbt_pkg::S_UD_DN2: begin
				if (flags.p_ge_dl) begin
					state_d = gbt_pkg::S_FOLLOW;
				end else begin
					ctl.op  = gbt_pkg::OP_P_INC;
					state_d = gbt_pkg::S_UD3;
				end
			end
			gbt_pkg::S_UD_UP: begin
				ctl.op  = gbt_pkg::OP_P_AM1;
				ret_d   = gbt_pkg::S_UD3;
				state_d = gbt_pkg::S_LB;
			end
			gbt_pkg::S_UD3: begin
				ctl.op  = gbt_pkg::OP_A_P;
				ret_d   = gbt_pkg::S_UD4;
				state_d = gbt_pkg::S_LS;
			end
			gbt_pkg::S_UD4: begin
				ctl.op  = gbt_pkg::OP_UD_TGT;
				ret_d   = gbt_pkg::S_FOLLOW;
				state_d = gbt_pkg::S_MV;
			end
			gbt_pkg::S_CC1: begin
				ctl.op  = gbt_pkg::OP_A_P;
				ret_d   = gbt_pkg::S_CC2;
				state_d = gbt_pkg::S_LS;
			end
			gbt_pkg::S_CC2: begin
				ctl.op  = gbt_pkg::OP_CC_LE;
				state_d = gbt_pkg::S_CC3;
			end
			gbt_pkg::S_CC3: begin
				if (flags.b_zero) begin
					ctl.op  = gbt_pkg::OP_SET_ST;
					ctl.st  = gbt_pkg::ST_NO_LINE;
					state_d = gbt_pkg::S_FOLLOW;
				end else if (flags.clip_ovf) begin
					ctl.op  = gbt_pkg::OP_SET_ST;
					ctl.st  = gbt_pkg::ST_CLIP_FULL;
					state_d = gbt_pkg::S_FOLLOW;
				end else begin
					ctl.op  = gbt_pkg::OP_CNT_CLR;
					state_d = gbt_pkg::S_CP_RD;
				end
			end
			gbt_pkg::S_CP_RD: begin
				if (flags.cnt_eq_b) begin
					state_d = gbt_pkg::S_CP_END;
				end else begin
					ctl.op  = gbt_pkg::OP_CP_RD;
					state_d = gbt_pkg::S_CP_WR;
				end
			end
			gbt_pkg::S_CP_WR: begin
				ctl.op  = gbt_pkg::OP_CP_WR;
				state_d = gbt_pkg::S_CP_RD;
			end
			gbt_pkg::S_CP_END: begin
				ctl.op = gbt_pkg::OP_CP_DONE;
				if (flags.key == gbt_pkg::KEY_CUT) begin
					ret_d   = gbt_pkg::S_CUT2;
					state_d = gbt_pkg::S_MV;
				end else begin
					state_d = gbt_pkg::S_FOLLOW;
				end
			end
			gbt_pkg::S_CUT2: begin
				ctl.op  = gbt_pkg::OP_CUT_FIX;
				state_d = gbt_pkg::S_FOLLOW;
			end
			gbt_pkg::S_PS_RD: begin
				if (flags.cnt_eq_clip) begin
					ctl.op  = gbt_pkg::OP_PS_DONE;
					state_d = gbt_pkg::S_FOLLOW;
				end else begin
					ctl.op  = gbt_pkg::OP_PS_RD;
					state_d = gbt_pkg::S_PS_WR;
				end
			end
			gbt_pkg::S_PS_WR: begin
				ctl.op  = gbt_pkg::OP_PS_WR;
				state_d = gbt_pkg::S_PS_RD;
			end
			// line start scan, returns through ret_q
			gbt_pkg::S_LB: begin
				if (flags.p_zero) begin
					state_d = ret_q;
				end else begin
					ctl.op  = gbt_pkg::OP_RD_PM1;
					state_d = gbt_pkg::S_LB_CHK;
				end
			end
			gbt_pkg::S_LB_CHK: begin
				if (flags.q_cr) begin
					state_d = ret_q;
				end else begin
					ctl.op  = gbt_pkg::OP_P_DEC;
					state_d = gbt_pkg::S_LB;
				end
			end
			// line end scan
			gbt_pkg::S_LS: begin
				if (flags.p_ge_dl) begin
					state_d = ret_q;
				end else begin
					ctl.op  = gbt_pkg::OP_RD_P;
					state_d = gbt_pkg::S_LS_CHK;
				end
			end
			gbt_pkg::S_LS_CHK: begin
				if (flags.q_cr) begin
					state_d = ret_q;
				end else begin
					ctl.op  = gbt_pkg::OP_P_INC;
					state_d = gbt_pkg::S_LS;
				end
			end
			// gap move: each character is read, then written across the gap
			gbt_pkg::S_MV: begin
				ctl.op  = gbt_pkg::OP_MV_CLAMP;
				state_d = gbt_pkg::S_MV_LOOP;
			end
			gbt_pkg::S_MV_LOOP: begin
				if (flags.t_lt_gs) begin
					ctl.op  = gbt_pkg::OP_MVL_RD;
					state_d = gbt_pkg::S_MVL_WR;
				end else if (flags.t_gt_gs) begin
					ctl.op  = gbt_pkg::OP_MVR_RD;
					state_d = gbt_pkg::S_MVR_WR;
				end else begin
					state_d = ret_q;
				end
			end
			gbt_pkg::S_MVL_WR: begin
				ctl.op  = gbt_pkg::OP_MVL_WR;
				state_d = gbt_pkg::S_MV_LOOP;
			end
			gbt_pkg::S_MVR_WR: begin
				ctl.op  = gbt_pkg::OP_MVR_WR;
				state_d = gbt_pkg::S_MV_LOOP;
			end
			// window follow
			gbt_pkg::S_FOLLOW: begin
				ctl.op  = gbt_pkg::OP_P_GS;
				ret_d   = gbt_pkg::S_FL1;
				state_d = gbt_pkg::S_LB;
			end
			gbt_pkg::S_FL1: begin
				ctl.op  = gbt_pkg::OP_A_P;
				state_d = gbt_pkg::S_FL2;
			end
			gbt_pkg::S_FL2: begin
				if (flags.a_lt_top) begin
					ctl.op  = gbt_pkg::OP_TOP_A;
					state_d = gbt_pkg::S_DONE;
				end else begin
					ctl.op  = gbt_pkg::OP_P_TOP;
					state_d = gbt_pkg::S_FL_CNT;
				end
			end
			gbt_pkg::S_FL_CNT: begin
				if (flags.p_lt_a) begin
					ctl.op  = gbt_pkg::OP_FC_RD;
					state_d = gbt_pkg::S_FL_CHK;
				end else begin
					state_d = gbt_pkg::S_FL_TRIM;
				end
			end
			gbt_pkg::S_FL_CHK: begin
				ctl.op  = gbt_pkg::OP_FC_CNT;
				state_d = gbt_pkg::S_FL_CNT;
			end
			gbt_pkg::S_FL_TRIM: begin
				if (flags.rows_ge_win) begin
					ctl.op  = gbt_pkg::OP_P_TOP2;
					ret_d   = gbt_pkg::S_FL_TRIM2;
					state_d = gbt_pkg::S_LS;
				end else begin
					state_d = gbt_pkg::S_DONE;
				end
			end
			gbt_pkg::S_FL_TRIM2: begin
				ctl.op  = gbt_pkg::OP_TOP_P1;
				state_d = gbt_pkg::S_FL_TRIM;
			end
			gbt_pkg::S_DONE: begin
				if (flags.out_free) begin
					ctl.op  = gbt_pkg::OP_OUT;
					state_d = gbt_pkg::S_IDLE;
				end
			end
			default: state_d = gbt_pkg::S_IDLE;
		endcase
	end

endmodule

// ----- design/gbt_dpath.sv -----
// datapath of the gap buffer edit engine: pointers, text and clipboard memories
// uses gbt_pkg command, flag and payload types
module gbt_dpath #(
	parameter int BUF_SIZE    = 32768,
	parameter int CLIP_SIZE   = 2048,
	parameter int WINDOW_ROWS = 23
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gbt_pkg::dp_cmd_t    ctl,
	output gbt_pkg::dp_flags_t  flags,
	input  gbt_pkg::in_item_t   in_data,
	input  logic                out_ready,
	output logic                out_valid,
	output gbt_pkg::out_item_t  out_data
);

	localparam int PW = $clog2(BUF_SIZE + 1);
	localparam int TA = $clog2(BUF_SIZE);
	localparam int CW = $clog2(CLIP_SIZE + 1);
	localparam int CA = $clog2(CLIP_SIZE);
	localparam int NW = (PW > CW) ? PW : CW;

	logic [7:0] text_mem [BUF_SIZE];
	logic [7:0] clip_mem [CLIP_SIZE];

	logic [PW-1:0] gs_q, ge_q, top_q;
	logic [CW-1:0] clip_q;
	logic          dirty_q, chain_q, out_valid_q;
	logic [PW-1:0] p_q, a_q, b_q, col_q, t_q;
	logic [NW-1:0] cnt_q;
	logic          req_q;
	logic [7:0]    key_q, rd_q;
	logic [14:0]   off_q;
	logic [2:0]    stat_q;
	gbt_pkg::out_item_t out_q;

	logic [7:0]    text_rq, clip_rq;
	logic [PW-1:0] dl, gap, lidx, diff, le;
	logic [PW:0]   psum;
	logic [TA-1:0] t_ra, t_wa;
	logic [7:0]    t_wd;
	logic          t_re, t_we, c_re, c_we;
	logic [NW:0]   cwa;
	logic          ld_out;

	assign gap  = ge_q - gs_q;
	assign dl   = PW'(BUF_SIZE) - gap;
	assign diff = p_q - a_q;
	assign le   = (p_q < dl) ? p_q + 1'b1 : p_q;
	assign cwa  = (NW+1)'(clip_q) + (NW+1)'(cnt_q);
	assign ld_out = (ctl.op == gbt_pkg::OP_OUT);

	// logical index to physical address across the gap
	always_comb begin
		case (ctl.op)
			gbt_pkg::OP_RD_OFF: lidx = PW'(off_q);
			gbt_pkg::OP_RD_PM1: lidx = p_q - 1'b1;
			gbt_pkg::OP_CP_RD:  lidx = a_q + cnt_q[PW-1:0];
			default:            lidx = p_q;
		endcase
		psum = (lidx < gs_q) ? {1'b0, lidx} : {1'b0, lidx} + {1'b0, gap};
	end

	always_comb begin
		t_re = 1'b0;
		t_we = 1'b0;
		t_ra = psum[TA-1:0];
		t_wa = gs_q[TA-1:0];
		t_wd = key_q;
		c_re = 1'b0;
		c_we = 1'b0;
		case (ctl.op)
			gbt_pkg::OP_RD_OFF, gbt_pkg::OP_RD_PM1, gbt_pkg::OP_RD_P,
			gbt_pkg::OP_CP_RD, gbt_pkg::OP_FC_RD: t_re = 1'b1;
			gbt_pkg::OP_MVL_RD: begin
				t_re = 1'b1;
				t_ra = TA'(gs_q - 1'b1);
			end
			gbt_pkg::OP_MVR_RD: begin
				t_re = 1'b1;
				t_ra = ge_q[TA-1:0];
			end
			gbt_pkg::OP_MVL_WR: begin
				t_we = 1'b1;
				t_wa = TA'(ge_q - 1'b1);
				t_wd = text_rq;
			end
			gbt_pkg::OP_MVR_WR: begin
				t_we = 1'b1;
				t_wd = text_rq;
			end
			gbt_pkg::OP_PUT: t_we = (gs_q < ge_q);
			gbt_pkg::OP_PS_WR: begin
				t_we = 1'b1;
				t_wd = clip_rq;
			end
			gbt_pkg::OP_PS_RD: c_re = 1'b1;
			gbt_pkg::OP_CP_WR: c_we = 1'b1;
			default: t_re = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (t_we)
			text_mem[t_wa] <= t_wd;
		if (t_re)
			text_rq <= text_mem[t_ra];
	end

	always_ff @(posedge clk) begin
		if (c_we)
			clip_mem[cwa[CA-1:0]] <= text_rq;
		if (c_re)
			clip_rq <= clip_mem[cnt_q[CA-1:0]];
	end

	// editor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_q        <= '0;
			ge_q        <= PW'(BUF_SIZE);
			top_q       <= '0;
			clip_q      <= '0;
			dirty_q     <= 1'b0;
			chain_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (ctl.op)
				gbt_pkg::OP_LATCH: begin
					if (!in_data.req_type && in_data.key_code != gbt_pkg::KEY_CUT &&
					    in_data.key_code != gbt_pkg::KEY_COPY)
						chain_q <= 1'b0;
				end
				gbt_pkg::OP_PUT: begin
					if (gs_q < ge_q) begin
						gs_q    <= gs_q + 1'b1;
						dirty_q <= 1'b1;
					end
				end
				gbt_pkg::OP_DEL: begin
					if (gs_q != '0) begin
						gs_q    <= gs_q - 1'b1;
						dirty_q <= 1'b1;
					end
				end
				gbt_pkg::OP_MVL_WR: begin
					gs_q <= gs_q - 1'b1;
					ge_q <= ge_q - 1'b1;
				end
				gbt_pkg::OP_MVR_WR: begin
					gs_q <= gs_q + 1'b1;
					ge_q <= ge_q + 1'b1;
				end
				gbt_pkg::OP_CC_LE: begin
					if (!chain_q)
						clip_q <= '0;
				end
				gbt_pkg::OP_CP_DONE: begin
					clip_q  <= clip_q + CW'(b_q);
					chain_q <= 1'b1;
				end
				gbt_pkg::OP_CUT_FIX: begin
					ge_q    <= ge_q + b_q;
					dirty_q <= 1'b1;
				end
				gbt_pkg::OP_PS_WR: gs_q <= gs_q + 1'b1;
				gbt_pkg::OP_PS_DONE: dirty_q <= 1'b1;
				gbt_pkg::OP_TOP_A: top_q <= a_q;
				gbt_pkg::OP_TOP_P1: top_q <= p_q + 1'b1;
				default: top_q <= top_q;
			endcase
		end
	end

	// scratch and per-request registers
	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_q.cursor_pos    <= 16'(gs_q);
			out_q.doc_length    <= 16'(dl);
			out_q.cursor_column <= 16'(gs_q - a_q);
			out_q.window_top    <= 16'(top_q);
			out_q.clip_length   <= 12'(clip_q);
			out_q.dirty         <= dirty_q;
			out_q.status        <= stat_q;
			out_q.read_char     <= rd_q;
		end
		case (ctl.op)
			gbt_pkg::OP_LATCH: begin
				req_q  <= in_data.req_type;
				key_q  <= in_data.key_code;
				off_q  <= in_data.read_offset;
				rd_q   <= 8'h00;
				stat_q <= gbt_pkg::ST_OK;
			end
			gbt_pkg::OP_RD_SAVE: rd_q <= text_rq;
			gbt_pkg::OP_P_GS: p_q <= gs_q;
			gbt_pkg::OP_P_DEC: p_q <= p_q - 1'b1;
			gbt_pkg::OP_P_INC: p_q <= p_q + 1'b1;
			gbt_pkg::OP_T_GSM1: t_q <= gs_q - 1'b1;
			gbt_pkg::OP_T_GSP1: t_q <= gs_q + 1'b1;
			gbt_pkg::OP_T_P: t_q <= p_q;
			gbt_pkg::OP_MV_CLAMP: begin
				if (t_q > dl)
					t_q <= dl;
			end
			gbt_pkg::OP_UD_SAVE: begin
				a_q   <= p_q;
				col_q <= gs_q - p_q;
			end
			gbt_pkg::OP_P_AM1: p_q <= a_q - 1'b1;
			gbt_pkg::OP_A_P: a_q <= p_q;
			gbt_pkg::OP_UD_TGT: t_q <= a_q + ((col_q > diff) ? diff : col_q);
			gbt_pkg::OP_CC_LE: b_q <= le - a_q;
			gbt_pkg::OP_CNT_CLR: cnt_q <= '0;
			gbt_pkg::OP_CP_WR: cnt_q <= cnt_q + 1'b1;
			gbt_pkg::OP_CP_DONE: t_q <= a_q;
			gbt_pkg::OP_PS_WR: cnt_q <= cnt_q + 1'b1;
			gbt_pkg::OP_SET_ST: stat_q <= ctl.st;
			gbt_pkg::OP_P_TOP: begin
				p_q   <= top_q;
				cnt_q <= '0;
			end
			gbt_pkg::OP_P_TOP2: p_q <= top_q;
			gbt_pkg::OP_FC_CNT: begin
				if (text_rq == gbt_pkg::KEY_CR)
					cnt_q <= cnt_q + 1'b1;
				p_q <= p_q + 1'b1;
			end
			gbt_pkg::OP_TOP_P1: cnt_q <= cnt_q - 1'b1;
			default: p_q <= p_q;
		endcase
	end

	always_comb begin
		flags.req_type    = req_q;
		flags.key         = key_q;
		flags.p_zero      = (p_q == '0);
		flags.p_ge_dl     = (p_q >= dl);
		flags.q_cr        = (text_rq == gbt_pkg::KEY_CR);
		flags.off_lt_dl   = (17'(off_q) < 17'(dl));
		flags.gs_zero     = (gs_q == '0);
		flags.gs_lt_dl    = (gs_q < dl);
		flags.t_lt_gs     = (t_q < gs_q);
		flags.t_gt_gs     = (t_q > gs_q);
		flags.b_zero      = (b_q == '0);
		flags.clip_ovf    = ((NW+1)'(clip_q) + (NW+1)'(b_q)) > (NW+1)'(CLIP_SIZE);
		flags.clip_zero   = (clip_q == '0);
		flags.paste_nofit = (NW'(gap) < NW'(clip_q));
		flags.cnt_eq_b    = (cnt_q == NW'(b_q));
		flags.cnt_eq_clip = (cnt_q == NW'(clip_q));
		flags.a_lt_top    = (a_q < top_q);
		flags.p_lt_a      = (p_q < a_q);
		flags.rows_ge_win = (cnt_q >= NW'(WINDOW_ROWS));
		flags.out_free    = !out_valid_q || out_ready;
		flags.gap_ok      = (gs_q <= ge_q);
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- design/gap_buffer_text_edit_engine_unit.sv -----
// gap buffer text edit engine: one transaction in, one transaction out per item
// latency is data dependent: each character walked by a gap move, line scan, window
// row count or clipboard copy takes a read state and a following state, on top of the
// decode and result states; full buffers give the longest items. one item at a time,
// the single text memory port sets the pace. a finished result waits in an output
// register while the next is taken. reset: asynchronous arst_n, empty document,
// cursor and window at 0, empty clipboard. memories are not cleared
`include "gap_buffer_text_edit_engine_unit_defines.svh"

module gap_buffer_text_edit_engine_unit #(
	parameter int BUF_SIZE    = 32768,
	parameter int CLIP_SIZE   = 2048,
	parameter int WINDOW_ROWS = 23
) (
	input logic clk,
	input logic arst_n,
	gbt_chan_if.sink   cmd,
	gbt_chan_if.source rsp
);

	// command and status bundle between sequencer and datapath
	gbt_pkg::dp_cmd_t   ctl;
	gbt_pkg::dp_flags_t flags;

	// sequencer: key decode, line scans, gap moves, window follow
	gbt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (cmd.ready),
		.flags    (flags),
		.ctl      (ctl)
	);

	// datapath: gap pointers, text store, clipboard, result register
	gbt_dpath #(
		.BUF_SIZE    (BUF_SIZE),
		.CLIP_SIZE   (CLIP_SIZE),
		.WINDOW_ROWS (WINDOW_ROWS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.flags     (flags),
		.in_data   (cmd.data),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.out_data  (rsp.data)
	);

	// one transaction in flight: an accepted request closes the input at once
	`GBT_ASSERT_NXT(a_single_item, cmd.valid && cmd.ready, !cmd.ready)
	// gap start never passes gap end
	`GBT_ASSERT_IMP(a_gap_order, 1'b1, flags.gap_ok)
	// a result is only loaded when the output register can take it
	`GBT_ASSERT_IMP(a_out_load, ctl.op == gbt_pkg::OP_OUT, flags.out_free)

endmodule

// ----- bench/tb_gap_buffer_text_edit_engine_unit.sv -----
// testbench for the gap buffer text edit engine: keystroke and read transactions
// are checked against a behavioral copy of the editor kept in this file
// depends on gbt_pkg, gbt_chan_if and gap_buffer_text_edit_engine_unit
`timescale 1ns / 100ps

module tb_gap_buffer_text_edit_engine_unit;

	localparam int BUF_SIZE    = 32768;
	localparam int CLIP_SIZE   = 2048;
	localparam int WINDOW_ROWS = 23;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int N_RANDOM    = 60;
	localparam logic [7:0] KEY_SAVE = 8'h0F;
	localparam logic [7:0] KEY_EXIT = 8'h18;
	localparam logic REQ_KEY  = 1'b0;
	localparam logic REQ_READ = 1'b1;

	logic clk;
	logic arst_n;

	gbt_chan_if #(.payload_t(gbt_pkg::in_item_t))  cmd ();
	gbt_chan_if #(.payload_t(gbt_pkg::out_item_t)) rsp ();

	gap_buffer_text_edit_engine_unit #(
		.BUF_SIZE(BUF_SIZE),
		.CLIP_SIZE(CLIP_SIZE),
		.WINDOW_ROWS(WINDOW_ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.rsp(rsp)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// editor state mirrored by the bench; the document is kept flat (no gap)
	// and the cursor is an index into it, which gives the same visible behavior
	logic [7:0] doc [$];
	logic [7:0] clip [$];
	int unsigned cursor;
	int unsigned top_line;
	logic        changed;
	logic        chain;

	gbt_pkg::out_item_t expected_q [$];
	gbt_pkg::out_item_t last_got;
	int        errors = 0;
	int        cycles = 0;
	bit        idle_free;

	function automatic int unsigned line_head(int unsigned p);
		while (p > 0 && doc[p - 1] != gbt_pkg::KEY_CR)
			p--;
		return p;
	endfunction

	function automatic int unsigned line_tail(int unsigned p);
		while (p < doc.size() && doc[p] != gbt_pkg::KEY_CR)
			p++;
		return p;
	endfunction

	function automatic logic [2:0] take_line(bit cut);
		int unsigned ls;
		int unsigned le;
		int unsigned n;
		ls = line_head(cursor);
		le = line_tail(ls);
		if (le < doc.size())
			le++;
		n = le - ls;
		if (!chain)
			clip.delete();
		if (n == 0)
			return gbt_pkg::ST_NO_LINE;
		if (clip.size() + n > CLIP_SIZE)
			return gbt_pkg::ST_CLIP_FULL;
		for (int i = 0; i < n; i++)
			clip.push_back(doc[ls + i]);
		if (cut) begin
			for (int i = 0; i < n; i++)
				doc.delete(ls);
			cursor = ls;
			changed = 1'b1;
		end
		chain = 1'b1;
		return gbt_pkg::ST_OK;
	endfunction

	function automatic void insert_char(logic [7:0] c);
		if (doc.size() >= BUF_SIZE)
			return;
		doc.insert(cursor, c);
		cursor++;
		changed = 1'b1;
	endfunction

	function automatic void vertical_move(bit down);
		int unsigned ls;
		int unsigned col;
		int unsigned t;
		int unsigned e;
		ls  = line_head(cursor);
		col = cursor - ls;
		if (down) begin
			e = line_tail(cursor);
			if (e >= doc.size())
				return;
			t = e + 1;
		end else begin
			if (ls == 0)
				return;
			t = line_head(ls - 1);
		end
		e = line_tail(t);
		cursor = t + ((col > e - t) ? e - t : col);
	endfunction

	function automatic void scroll_window();
		int unsigned cl;
		int unsigned rows;
		cl   = line_head(cursor);
		rows = 0;
		if (cl < top_line) begin
			top_line = cl;
			return;
		end
		for (int unsigned p = top_line; p < cl; p++)
			if (doc[p] == gbt_pkg::KEY_CR)
				rows++;
		while (rows >= WINDOW_ROWS) begin
			top_line = line_tail(top_line) + 1;
			rows--;
		end
	endfunction

	// apply one accepted request to the mirror and return the result it gives
	function automatic gbt_pkg::out_item_t edit_step(gbt_pkg::in_item_t it);
		gbt_pkg::out_item_t r;
		logic [2:0] st;
		logic [7:0] rd;
		st = gbt_pkg::ST_OK;
		rd = 8'h00;
		if (it.req_type == REQ_READ) begin
			if (it.read_offset < doc.size())
				rd = doc[it.read_offset];
		end else begin
			if (it.key_code != gbt_pkg::KEY_CUT && it.key_code != gbt_pkg::KEY_COPY)
				chain = 1'b0;
			case (it.key_code)
				gbt_pkg::KEY_CUT:   st = take_line(1'b1);
				gbt_pkg::KEY_COPY:  st = take_line(1'b0);
				gbt_pkg::KEY_PASTE: begin
					if (clip.size() == 0)
						st = gbt_pkg::ST_CLIP_EMPTY;
					else if (BUF_SIZE - doc.size() < clip.size())
						st = gbt_pkg::ST_BUF_FULL;
					else begin
						foreach (clip[i]) begin
							doc.insert(cursor, clip[i]);
							cursor++;
						end
						changed = 1'b1;
					end
				end
				gbt_pkg::KEY_CTRL_A, gbt_pkg::KEY_HOME: cursor = line_head(cursor);
				gbt_pkg::KEY_CTRL_E: cursor = line_tail(cursor);
				gbt_pkg::KEY_LEFT: if (cursor > 0) cursor--;
				gbt_pkg::KEY_RIGHT: if (cursor < doc.size()) cursor++;
				gbt_pkg::KEY_UP:   vertical_move(1'b0);
				gbt_pkg::KEY_DOWN: vertical_move(1'b1);
				gbt_pkg::KEY_DEL: begin
					// removes the character just before the cursor
					if (cursor > 0) begin
						doc.delete(cursor - 1);
						cursor--;
						changed = 1'b1;
					end
				end
				gbt_pkg::KEY_CR: insert_char(gbt_pkg::KEY_CR);
				default: begin
					if (it.key_code >= gbt_pkg::KEY_PRINT_LO &&
					    it.key_code <= gbt_pkg::KEY_PRINT_HI)
						insert_char(it.key_code);
				end
			endcase
			scroll_window();
		end
		r.cursor_pos    = 16'(cursor);
		r.doc_length    = 16'(doc.size());
		r.cursor_column = 16'(cursor - line_head(cursor));
		r.window_top    = 16'(top_line);
		r.clip_length   = 12'(clip.size());
		r.dirty         = changed;
		r.status        = st;
		r.read_char     = rd;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	function automatic bit idle_roll();
		return !idle_free && ($urandom_range(99) < 28);
	endfunction

	// drive one request at a falling edge and hold it until the engine takes it;
	// valid stays high on return, the next send or a drain replaces it
	task automatic send(logic rq, logic [7:0] k, logic [14:0] off);
		while (idle_roll()) begin
			cmd.valid <= 1'b0;
			@(negedge clk);
		end
		cmd.valid            <= 1'b1;
		cmd.data.req_type    <= rq;
		cmd.data.key_code    <= k;
		cmd.data.read_offset <= off;
		do
			@(posedge clk);
		while (!cmd.ready);
		@(negedge clk);
	endtask

	// drop valid and wait until every expected result has come back
	task automatic drain();
		cmd.valid <= 1'b0;
		do
			@(negedge clk);
		while (expected_q.size() != 0);
	endtask

	// directed rows; typed expectations only where obvious, the rest from the mirror
	typedef struct {
		logic        rq;
		logic [7:0]  k;
		logic [14:0] off;
		bit          has_st;
		logic [2:0]  st;
	} row_t;

	row_t dir_rows [$];

	function automatic void add_row(logic rq, logic [7:0] k, logic [14:0] off,
			bit has_st = 0, logic [2:0] st = gbt_pkg::ST_OK);
		row_t r;
		r.rq = rq; r.k = k; r.off = off; r.has_st = has_st; r.st = st;
		dir_rows.push_back(r);
	endfunction

	// key pool for random edits: weighted toward typing with some moves and clipboard
	function automatic logic [7:0] pick_key();
		int unsigned d;
		d = $urandom_range(99);
		if (d < 35) return 8'($urandom_range(gbt_pkg::KEY_PRINT_LO, gbt_pkg::KEY_PRINT_HI));
		if (d < 45) return gbt_pkg::KEY_CR;
		if (d < 50) return gbt_pkg::KEY_DEL;
		if (d < 54) return gbt_pkg::KEY_LEFT;
		if (d < 57) return gbt_pkg::KEY_RIGHT;
		if (d < 61) return gbt_pkg::KEY_UP;
		if (d < 65) return gbt_pkg::KEY_DOWN;
		if (d < 67) return gbt_pkg::KEY_HOME;
		if (d < 69) return gbt_pkg::KEY_CTRL_A;
		if (d < 71) return gbt_pkg::KEY_CTRL_E;
		if (d < 76) return gbt_pkg::KEY_CUT;
		if (d < 81) return gbt_pkg::KEY_COPY;
		if (d < 86) return gbt_pkg::KEY_PASTE;
		if (d < 88) return KEY_SAVE;
		if (d < 89) return KEY_EXIT;
		return 8'($urandom_range(255));
	endfunction

	// response side: random stall, compare against oldest expectation
	always @(negedge clk) begin
		if (arst_n)
			rsp.ready <= !idle_roll();
	end

	always @(posedge clk) begin
		gbt_pkg::out_item_t w;
		gbt_pkg::out_item_t g;
		if (arst_n && rsp.valid && rsp.ready) begin
			g = rsp.data;
			last_got = g;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result transaction", 1, 0);
			end else begin
				w = expected_q.pop_front();
				if (g.cursor_pos !== w.cursor_pos)
					report_mismatch("cursor_pos", int'(g.cursor_pos), int'(w.cursor_pos));
				if (g.doc_length !== w.doc_length)
					report_mismatch("doc_length", int'(g.doc_length), int'(w.doc_length));
				if (g.cursor_column !== w.cursor_column)
					report_mismatch("cursor_column", int'(g.cursor_column),
						int'(w.cursor_column));
				if (g.window_top !== w.window_top)
					report_mismatch("window_top", int'(g.window_top), int'(w.window_top));
				if (g.clip_length !== w.clip_length)
					report_mismatch("clip_length", int'(g.clip_length), int'(w.clip_length));
				if (g.dirty !== w.dirty)
					report_mismatch("dirty", int'(g.dirty), int'(w.dirty));
				if (g.status !== w.status)
					report_mismatch("status", int'(g.status), int'(w.status));
				if (g.read_char !== w.read_char)
					report_mismatch("read_char", int'(g.read_char), int'(w.read_char));
			end
		end
	end

	// prediction at the accepting edge keeps request order
	always @(posedge clk) begin
		if (arst_n && cmd.valid && cmd.ready)
			expected_q.push_back(edit_step(cmd.data));
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic [7:0]  k;
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.data = '0;
		rsp.ready = 1'b0;
		idle_free = 0;
		cursor = 0;
		top_line = 0;
		changed = 1'b0;
		chain = 1'b0;

		// directed: empty-document cases first
		add_row(REQ_READ, 8'hFF, 15'h7FFF);           // read past end of empty document
		add_row(REQ_KEY, gbt_pkg::KEY_PASTE, 15'h0, 1, gbt_pkg::ST_CLIP_EMPTY);
		add_row(REQ_KEY, gbt_pkg::KEY_CUT, 15'h0, 1, gbt_pkg::ST_NO_LINE);
		add_row(REQ_KEY, gbt_pkg::KEY_DEL, 15'h0, 1, gbt_pkg::ST_OK); // nothing before cursor
		add_row(REQ_KEY, gbt_pkg::KEY_LEFT, 15'h0, 1, gbt_pkg::ST_OK);
		add_row(REQ_KEY, gbt_pkg::KEY_PRINT_LO, 15'h0);
		add_row(REQ_KEY, gbt_pkg::KEY_PRINT_HI, 15'h0);
		add_row(REQ_KEY, gbt_pkg::KEY_CR, 15'h0);
		add_row(REQ_KEY, 8'h41, 15'h0);
		add_row(REQ_KEY, gbt_pkg::KEY_UP, 15'h0);
		add_row(REQ_KEY, gbt_pkg::KEY_CTRL_E, 15'h0);
		add_row(REQ_KEY, gbt_pkg::KEY_DOWN, 15'h0);
		add_row(REQ_KEY, gbt_pkg::KEY_HOME, 15'h0);
		add_row(REQ_KEY, gbt_pkg::KEY_RIGHT, 15'h0);
		add_row(REQ_KEY, gbt_pkg::KEY_CTRL_A, 15'h0);
		add_row(REQ_KEY, gbt_pkg::KEY_COPY, 15'h0);
		add_row(REQ_KEY, gbt_pkg::KEY_COPY, 15'h0);    // chained copy appends
		add_row(REQ_KEY, KEY_SAVE, 15'h0);             // breaks the chain
		add_row(REQ_KEY, gbt_pkg::KEY_CUT, 15'h0);
		add_row(REQ_KEY, gbt_pkg::KEY_PASTE, 15'h0);
		add_row(REQ_KEY, KEY_EXIT, 15'h0);
		add_row(REQ_KEY, 8'h7F, 15'h0);                // unknown key
		add_row(REQ_KEY, 8'hFF, 15'h0);
		add_row(REQ_READ, 8'h00, 15'h0001);
		add_row(REQ_KEY, gbt_pkg::KEY_DEL, 15'h0);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			send(dir_rows[i].rq, dir_rows[i].k, dir_rows[i].off);
			if (dir_rows[i].has_st) begin
				// typed status checked against the transaction that came back
				drain();
				if (last_got.status !== dir_rows[i].st)
					report_mismatch("directed status", int'(last_got.status),
						int'(dir_rows[i].st));
			end
		end

		// hold the sender until every expected result has drained
		drain();

		// random part: short lines of typing mixed with moves and clipboard work
		// and a stretch with no idling on either side
		for (int n = 0; n < N_RANDOM; n++) begin
			idle_free = (n >= 20 && n < 45);
			if ($urandom_range(9) == 0)
				send(REQ_READ, 8'($urandom_range(255)),
					($urandom_range(3) == 0) ? 15'($urandom_range(32767))
						: 15'($urandom_range(doc.size() + 2)));
			else begin
				k = pick_key();
				send(REQ_KEY, k, 15'($urandom_range(32767)));
			end
		end
		// push enough lines to make the window scroll
		idle_free = 0;
		repeat (WINDOW_ROWS + 3) send(REQ_KEY, gbt_pkg::KEY_CR, 15'h0);
		repeat (WINDOW_ROWS + 3) send(REQ_KEY, gbt_pkg::KEY_UP, 15'h0);
		repeat (4) send(REQ_KEY, gbt_pkg::KEY_DOWN, 15'h0);

		drain();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+design
design/gbt_pkg.sv
design/gbt_chan_if.sv
design/gbt_ctrl.sv
design/gbt_dpath.sv
design/gap_buffer_text_edit_engine_unit.sv
bench/tb_gap_buffer_text_edit_engine_unit.sv
